// File: hdl/bscp_pkg.sv
package bscp_pkg;

    // Sizes
    localparam int CLIENTS     = 16;
    localparam int CREDIT_BITS = 48;
    localparam int IDX_W       = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
    localparam int CNT_W       = $clog2(CREDIT_BITS + 1);

    // Fixed field widths
    localparam int MODE_W    = 2;
    localparam int CLIENT_W  = 4;
    localparam int FIELD_W   = 48;
    localparam int BCOUNT_W  = 16;
    localparam int CFG_IDX_W = 1;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_DEC     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INC     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FREE    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RESTART = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_QUOTA_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BATCH_COUNT = 1'b1;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_LOAD,
        OP_ACQ,
        OP_TAKE,
        OP_SAVE_RN,
        OP_BULK_PREP,
        OP_BULK,
        OP_RESTART,
        OP_SIMPLE,
        OP_FINISH
    } dp_op_t;

    // Divider operand selection
    typedef enum logic [1:0] {
        SEL_NEED,
        SEL_POOL,
        SEL_QUOTA
    } div_sel_t;

    typedef struct packed {
        dp_op_t   op;
        logic     div_start;
        div_sel_t div_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              valid;
        logic              hold;
        logic              pool_zero;
        logic              need_le_loc;
        logic              pool_ge_bs;
        logic              bulk_fit;
        logic              div_done;
    } dp_stat_t;

endpackage

// File: hdl/bscp_div.sv
// Restoring divider: one quotient bit per cycle, CREDIT_BITS quotient bits per division.
module bscp_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [bscp_pkg::CREDIT_BITS-1:0]  dividend,
    input  logic [bscp_pkg::CREDIT_BITS-1:0]  divisor,
    output logic [bscp_pkg::CREDIT_BITS-1:0]  quotient,
    output logic [bscp_pkg::CREDIT_BITS-1:0]  remainder,
    output logic                              done
);

    localparam int W = bscp_pkg::CREDIT_BITS;

    logic [W-1:0]                 rem_reg;
    logic [W-1:0]                 quo_reg;
    logic [W-1:0]                 dvs_reg;
    logic [bscp_pkg::CNT_W-1:0]   cnt_reg;
    logic                         run_reg;
    logic                         done_reg;

    logic [W:0]   shifted;
    logic         ge;
    logic [W:0]   diff;

    // Trial subtract of the shifted partial remainder
    assign shifted = {rem_reg, quo_reg[W-1]};
    assign ge      = (shifted >= {1'b0, dvs_reg});
    assign diff    = shifted - {1'b0, dvs_reg};

    // Control: iteration count and completion pulse
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == bscp_pkg::CNT_W'(W - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift in dividend bits, keep remainder and quotient
    always_ff @(posedge clk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (run_reg) begin
            rem_reg <= ge ? diff[W-1:0] : shifted[W-1:0];
            quo_reg <= {quo_reg[W-2:0], ge};
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

// File: hdl/bscp_dp.sv
// Datapath: pool, batch size, per-client credit, working registers and result registers.
module bscp_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bscp_pkg::dp_cmd_t                   cmd,
    output bscp_pkg::dp_stat_t                  stat,
    input  logic [bscp_pkg::MODE_W-1:0]         mode,
    input  logic [bscp_pkg::CLIENT_W-1:0]       client,
    input  logic [bscp_pkg::FIELD_W-1:0]        amount,
    input  logic                                cfg_we,
    input  logic [bscp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bscp_pkg::FIELD_W-1:0]        cfg_data,
    output logic [bscp_pkg::FIELD_W-1:0]        granted,
    output logic                                holds_batch,
    output logic [bscp_pkg::FIELD_W-1:0]        local_left,
    output logic [bscp_pkg::FIELD_W-1:0]        pool_left
);

    localparam int W = bscp_pkg::CREDIT_BITS;

    // Configuration
    logic [bscp_pkg::FIELD_W-1:0]   quota_reg;
    logic [bscp_pkg::BCOUNT_W-1:0]  bcount_reg;

    // Block state
    logic [W-1:0]                   pool_reg;
    logic [W-1:0]                   bs_reg;
    logic [W-1:0]                   local_credit_reg [bscp_pkg::CLIENTS];
    logic [bscp_pkg::CLIENTS-1:0]   holding_reg;

    // Working registers for the item in flight
    logic [bscp_pkg::MODE_W-1:0]    mode_reg;
    logic [bscp_pkg::CLIENT_W-1:0]  client_reg;
    logic [W-1:0]                   need_reg;
    logic [W-1:0]                   grant_reg;
    logic [W-1:0]                   loc_reg;
    logic                           hold_reg;
    logic [W-1:0]                   rn_reg;
    logic [W:0]                     ceil_reg;
    logic [W-1:0]                   floor_reg;

    // Result registers
    logic [bscp_pkg::FIELD_W-1:0]   granted_reg;
    logic                           holds_reg;
    logic [bscp_pkg::FIELD_W-1:0]   local_left_reg;
    logic [bscp_pkg::FIELD_W-1:0]   pool_left_reg;

    // Combinational helpers
    logic                           valid;
    logic [bscp_pkg::IDX_W-1:0]     idx;
    logic                           pool_ge_bs;
    logic                           need_le_loc;
    logic [W-1:0]                   half;
    logic [W-1:0]                   acq_b;
    logic [W-1:0]                   take_t;
    logic [W-1:0]                   need_after;
    logic [W-1:0]                   pad;
    logic                           bulk_fit;
    logic [W:0]                     free_sum;
    logic [W-1:0]                   pool_free_next;
    logic [bscp_pkg::BCOUNT_W-1:0]  bc_eff;
    logic [W-1:0]                   bs_next;
    logic [W-1:0]                   div_a;
    logic [W-1:0]                   div_b;
    logic [W-1:0]                   div_quo;
    logic [W-1:0]                   div_rem;
    logic                           div_done;

    assign valid       = (32'(client_reg) < bscp_pkg::CLIENTS);
    assign idx         = bscp_pkg::IDX_W'(client_reg);
    assign pool_ge_bs  = (pool_reg >= bs_reg);
    assign need_le_loc = (need_reg <= loc_reg);

    // Batch for one acquire: full size, else half the pool but at least one
    assign half  = pool_reg >> 1;
    assign acq_b = pool_ge_bs ? bs_reg : ((half == '0) ? W'(1) : half);

    // Take from local credit
    assign take_t     = need_le_loc ? need_reg : loc_reg;
    assign need_after = need_reg - take_t;

    // Round need up to whole batches; compare with whole batches in the pool
    assign pad      = (rn_reg == '0) ? '0 : (bs_reg - rn_reg);
    assign bulk_fit = (ceil_reg <= {1'b0, floor_reg});

    // Saturating return of local credit to the pool
    assign free_sum       = {1'b0, pool_reg} + {1'b0, loc_reg};
    assign pool_free_next = free_sum[W] ? '1 : free_sum[W-1:0];

    // Batch size from the restart division
    assign bc_eff  = (bcount_reg == '0) ? bscp_pkg::BCOUNT_W'(1) : bcount_reg;
    assign bs_next = (div_quo == '0) ? W'(1) : div_quo;

    // Divider operand selection
    always_comb begin
        case (cmd.div_sel)
            bscp_pkg::SEL_NEED:
            begin
                div_a = need_after;
                div_b = bs_reg;
            end
            bscp_pkg::SEL_POOL:
            begin
                div_a = pool_reg;
                div_b = bs_reg;
            end
            bscp_pkg::SEL_QUOTA:
            begin
                div_a = W'(quota_reg);
                div_b = W'(bc_eff);
            end
            default:
            begin
                div_a = pool_reg;
                div_b = bs_reg;
            end
        endcase
    end

    bscp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .quotient  (div_quo),
        .remainder (div_rem),
        .done      (div_done)
    );

    // Status to the controller
    assign stat.mode        = mode_reg;
    assign stat.valid       = valid;
    assign stat.hold        = holding_reg[idx];
    assign stat.pool_zero   = (pool_reg == '0);
    assign stat.need_le_loc = need_le_loc;
    assign stat.pool_ge_bs  = pool_ge_bs;
    assign stat.bulk_fit    = bulk_fit;
    assign stat.div_done    = div_done;

    // Configuration, pool, batch size and client table
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            quota_reg   <= '0;
            bcount_reg  <= bscp_pkg::BCOUNT_W'(1);
            pool_reg    <= '0;
            bs_reg      <= W'(1);
            holding_reg <= '0;
            for (int i = 0; i < bscp_pkg::CLIENTS; i++) begin
                local_credit_reg[i] <= '0;
            end
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    bscp_pkg::CFG_QUOTA_LIMIT: quota_reg  <= cfg_data;
                    bscp_pkg::CFG_BATCH_COUNT: bcount_reg <= cfg_data[bscp_pkg::BCOUNT_W-1:0];
                    default: ;
                endcase
            end
            case (cmd.op)
                bscp_pkg::OP_ACQ:
                begin
                    if (pool_reg != '0) begin
                        pool_reg <= pool_reg - acq_b;
                    end
                end
                bscp_pkg::OP_BULK:
                begin
                    if (bulk_fit) begin
                        pool_reg <= pool_reg - ceil_reg[W-1:0];
                    end
                    else begin
                        pool_reg <= pool_reg - floor_reg;
                    end
                end
                bscp_pkg::OP_RESTART:
                begin
                    pool_reg    <= W'(quota_reg);
                    bs_reg      <= bs_next;
                    holding_reg <= '0;
                    for (int i = 0; i < bscp_pkg::CLIENTS; i++) begin
                        local_credit_reg[i] <= '0;
                    end
                end
                bscp_pkg::OP_SIMPLE:
                begin
                    if (mode_reg == bscp_pkg::MODE_FREE && hold_reg) begin
                        pool_reg <= pool_free_next;
                    end
                end
                bscp_pkg::OP_FINISH:
                begin
                    if (valid && mode_reg != bscp_pkg::MODE_RESTART) begin
                        local_credit_reg[idx] <= loc_reg;
                        holding_reg[idx]      <= hold_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    // Working and result registers
    always_ff @(posedge clk) begin
        case (cmd.op)
            bscp_pkg::OP_LATCH:
            begin
                mode_reg   <= mode;
                client_reg <= client;
                need_reg   <= W'(amount);
                grant_reg  <= '0;
            end
            bscp_pkg::OP_LOAD:
            begin
                loc_reg  <= local_credit_reg[idx];
                hold_reg <= holding_reg[idx];
            end
            bscp_pkg::OP_ACQ:
            begin
                if (pool_reg == '0) begin
                    loc_reg  <= '0;
                    hold_reg <= 1'b0;
                end
                else begin
                    loc_reg  <= acq_b;
                    hold_reg <= 1'b1;
                end
            end
            bscp_pkg::OP_TAKE:
            begin
                loc_reg   <= loc_reg - take_t;
                grant_reg <= grant_reg + take_t;
                need_reg  <= need_after;
            end
            bscp_pkg::OP_SAVE_RN:
            begin
                rn_reg <= div_rem;
            end
            bscp_pkg::OP_BULK_PREP:
            begin
                ceil_reg  <= {1'b0, need_reg} + {1'b0, pad};
                floor_reg <= pool_reg - div_rem;
            end
            bscp_pkg::OP_BULK:
            begin
                if (bulk_fit) begin
                    loc_reg   <= ceil_reg[W-1:0] - need_reg;
                    hold_reg  <= 1'b1;
                    grant_reg <= grant_reg + need_reg;
                    need_reg  <= '0;
                end
                else begin
                    loc_reg   <= '0;
                    grant_reg <= grant_reg + floor_reg;
                    need_reg  <= need_reg - floor_reg;
                end
            end
            bscp_pkg::OP_RESTART:
            begin
                loc_reg  <= '0;
                hold_reg <= 1'b0;
            end
            bscp_pkg::OP_SIMPLE:
            begin
                case (mode_reg)
                    bscp_pkg::MODE_INC:
                    begin
                        if (hold_reg && loc_reg != '1) begin
                            loc_reg <= loc_reg + 1'b1;
                        end
                    end
                    bscp_pkg::MODE_FREE:
                    begin
                        if (hold_reg) begin
                            loc_reg  <= '0;
                            hold_reg <= 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
            bscp_pkg::OP_FINISH:
            begin
                granted_reg    <= bscp_pkg::FIELD_W'(grant_reg);
                holds_reg      <= valid & hold_reg;
                local_left_reg <= valid ? bscp_pkg::FIELD_W'(loc_reg) : '0;
                pool_left_reg  <= bscp_pkg::FIELD_W'(pool_reg);
            end
            default: ;
        endcase
    end

    assign granted     = granted_reg;
    assign holds_batch = holds_reg;
    assign local_left  = local_left_reg;
    assign pool_left   = pool_left_reg;

endmodule

// File: hdl/bscp_ctrl.sv
// Controller: sequences one request at a time through the datapath.
module bscp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    output logic                 done,
    output bscp_pkg::dp_cmd_t    cmd,
    input  bscp_pkg::dp_stat_t   stat
);

    typedef enum logic [11:0] {
        S_IDLE      = 12'b0000_0000_0001,
        S_LOAD      = 12'b0000_0000_0010,
        S_ACQ       = 12'b0000_0000_0100,
        S_TAKE      = 12'b0000_0000_1000,
        S_DIV_N     = 12'b0000_0001_0000,
        S_DIV_P     = 12'b0000_0010_0000,
        S_BULK_PREP = 12'b0000_0100_0000,
        S_BULK      = 12'b0000_1000_0000,
        S_DIV_R     = 12'b0001_0000_0000,
        S_RESTART   = 12'b0010_0000_0000,
        S_SIMPLE    = 12'b0100_0000_0000,
        S_DONE      = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   bulk_done_reg;
    logic   bulk_done_next;
    logic   done_reg;

    // Next state and datapath command
    always_comb begin
        state_next     = state_reg;
        bulk_done_next = bulk_done_reg;
        cmd.op         = bscp_pkg::OP_NONE;
        cmd.div_start  = 1'b0;
        cmd.div_sel    = bscp_pkg::SEL_NEED;
        case (state_reg)
            S_IDLE:
            begin
                if (start) begin
                    cmd.op     = bscp_pkg::OP_LATCH;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.op         = bscp_pkg::OP_LOAD;
                bulk_done_next = 1'b0;
                if (stat.mode == bscp_pkg::MODE_RESTART) begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = bscp_pkg::SEL_QUOTA;
                    state_next    = S_DIV_R;
                end
                else if (!stat.valid) begin
                    state_next = S_DONE;
                end
                else if (stat.mode == bscp_pkg::MODE_DEC) begin
                    state_next = stat.hold ? S_TAKE : S_ACQ;
                end
                else begin
                    state_next = S_SIMPLE;
                end
            end
            S_ACQ:
            begin
                cmd.op     = bscp_pkg::OP_ACQ;
                state_next = stat.pool_zero ? S_DONE : S_TAKE;
            end
            S_TAKE:
            begin
                cmd.op = bscp_pkg::OP_TAKE;
                if (stat.need_le_loc) begin
                    state_next = S_DONE;
                end
                else if (!bulk_done_reg && stat.pool_ge_bs) begin
                    // take whole batches at once
                    cmd.div_start  = 1'b1;
                    cmd.div_sel    = bscp_pkg::SEL_NEED;
                    bulk_done_next = 1'b1;
                    state_next     = S_DIV_N;
                end
                else begin
                    bulk_done_next = 1'b1;
                    state_next     = S_ACQ;
                end
            end
            S_DIV_N:
            begin
                if (stat.div_done) begin
                    cmd.op        = bscp_pkg::OP_SAVE_RN;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = bscp_pkg::SEL_POOL;
                    state_next    = S_DIV_P;
                end
            end
            S_DIV_P:
            begin
                if (stat.div_done) begin
                    state_next = S_BULK_PREP;
                end
            end
            S_BULK_PREP:
            begin
                cmd.op     = bscp_pkg::OP_BULK_PREP;
                state_next = S_BULK;
            end
            S_BULK:
            begin
                cmd.op     = bscp_pkg::OP_BULK;
                state_next = stat.bulk_fit ? S_DONE : S_ACQ;
            end
            S_DIV_R:
            begin
                if (stat.div_done) begin
                    state_next = S_RESTART;
                end
            end
            S_RESTART:
            begin
                cmd.op     = bscp_pkg::OP_RESTART;
                state_next = S_DONE;
            end
            S_SIMPLE:
            begin
                cmd.op     = bscp_pkg::OP_SIMPLE;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                cmd.op     = bscp_pkg::OP_FINISH;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, bulk phase flag and result strobe
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            bulk_done_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            bulk_done_reg <= bulk_done_next;
            done_reg      <= (state_reg == S_DONE);
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

// File: hdl/batched_shared_credit_pool_unit.sv
// Shared credit pool with per-client batches. A request is taken when start is high
// and busy is low; its result appears on the result ports for exactly one cycle with
// done high, and must be captured then since the block cannot be held off. One request
// is worked on at a time. Increment and free pass from acceptance through S_LOAD and
// S_SIMPLE to S_DONE. Restart passes through S_LOAD, S_DIV_R and S_RESTART, waiting on
// the bit-serial divider that forms the batch size. A decrement goes from S_LOAD to
// S_TAKE when the client already holds a batch and to S_ACQ first when it does not;
// each further batch adds a pass through S_ACQ and S_TAKE (the pool is halved each
// time it holds less than a full batch), and an acquisition that finds the pool empty
// ends the request. Drawing whole batches adds S_DIV_N and S_DIV_P, two passes through
// the same divider, then S_BULK_PREP and S_BULK. busy is low in the cycle done is high,
// so the next request can be accepted right then. Configuration writes are always
// ready and should only be issued while busy is low.
module batched_shared_credit_pool_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    output logic                                done,
    input  logic [bscp_pkg::MODE_W-1:0]         mode,
    input  logic [bscp_pkg::CLIENT_W-1:0]       client,
    input  logic [bscp_pkg::FIELD_W-1:0]        amount,
    output logic [bscp_pkg::FIELD_W-1:0]        granted,
    output logic                                holds_batch,
    output logic [bscp_pkg::FIELD_W-1:0]        local_left,
    output logic [bscp_pkg::FIELD_W-1:0]        pool_left,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bscp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bscp_pkg::FIELD_W-1:0]        cfg_data
);

    bscp_pkg::dp_cmd_t  cmd;
    bscp_pkg::dp_stat_t stat;

    assign cfg_ready = 1'b1;

    bscp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .stat  (stat)
    );

    bscp_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .mode        (mode),
        .client      (client),
        .amount      (amount),
        .cfg_we      (cfg_valid & cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .granted     (granted),
        .holds_batch (holds_batch),
        .local_left  (local_left),
        .pool_left   (pool_left)
    );

    // Result strobe only shows once the block has gone idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while busy");

    // An accepted request makes the block busy next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // Result strobe lasts a single cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe longer than one cycle");

    // A client that holds no batch reports no local credit
    a_no_hold_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !holds_batch) |-> (local_left == '0))
        else $error("local credit reported without a batch");

endmodule
